>>> rtl/mfdr_pkg.sv
// mfdr_pkg: shared types, constants and helper functions of the mono frame
// dirty region block. No dependencies; used by every rtl/mfdr_* file.
package mfdr_pkg;

  // Default geometry limits and register geometry
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int DIM_W          = 13;   // frame_width / frame_height registers
  localparam int STRIDE_W       = 16;
  localparam int COUNT_W        = 25;
  localparam int COORD_W        = 12;
  localparam int QUEUE_DEPTH    = 4;
  localparam int PADDR_W        = 4;
  localparam int PDATA_W        = 32;

  // Register indexes (word address = paddr[3:2])
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ROW_STRIDE   = 2'd2;

  localparam logic [DIM_W-1:0]    FRAME_WIDTH_RST  = 13'd960;
  localparam logic [DIM_W-1:0]    FRAME_HEIGHT_RST = 13'd540;
  localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST   = 16'd120;

  typedef struct packed {
    logic [DIM_W-1:0]    frame_width;
    logic [DIM_W-1:0]    frame_height;
    logic [STRIDE_W-1:0] row_stride_bytes;
  } cfg_t;

  // One classified byte pair, front to back
  typedef struct packed {
    logic             bad_geom;   // unusable geometry: flush and emit zeros
    logic             frame_end;  // last byte of last row
    logic             stride_ok;
    logic             has_diff;
    logic [3:0]       ones;
    logic [DIM_W-1:0] first_pos;  // absolute column of leftmost change
    logic [DIM_W-1:0] last_pos;   // absolute column of rightmost change
    logic [DIM_W-1:0] row;
  } entry_t;

  typedef struct packed {
    logic               result_valid;
    logic [COUNT_W-1:0] changed_pixels;
    logic [COUNT_W-1:0] compared_pixels;
    logic               has_bounds;
    logic [COORD_W-1:0] box_x;
    logic [COORD_W-1:0] box_y;
    logic [DIM_W-1:0]   box_width;
    logic [DIM_W-1:0]   box_height;
  } result_t;

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    a = v - ((v >> 1) & 8'h55);
    b = (a & 8'h33) + ((a >> 2) & 8'h33);
    c = (b + (b >> 4)) & 8'h0F;
    return c[3:0];
  endfunction

  // Index (0 = MSB) of leftmost set bit
  function automatic logic [2:0] first_set(input logic [7:0] v);
    logic [2:0] idx;
    idx = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (v[7-i]) idx = 3'(i);
    end
    return idx;
  endfunction

  // Index (0 = MSB) of rightmost set bit
  function automatic logic [2:0] last_set(input logic [7:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[7-i]) idx = 3'(i);
    end
    return idx;
  endfunction

endpackage

>>> rtl/mfdr_front.sv
// mfdr_front: accepts byte pairs, tracks column/row position, masks the row
// tail and classifies each pair into an entry. Depends on mfdr_pkg.
module mfdr_front #(
  parameter int MAX_WIDTH  = mfdr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mfdr_pkg::MAX_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               clr,
  input  mfdr_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         prev_byte,
  input  logic [7:0]         next_byte,
  input  logic               q_full,
  output logic               q_wr,
  output mfdr_pkg::entry_t   q_entry
);

  localparam int DIM_MAX = (1 << mfdr_pkg::DIM_W) - 1;
  localparam int EFF_W   = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
  localparam int EFF_H   = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
  localparam int VIS_MAX = (EFF_W + 7) / 8;
  localparam int CW      = (VIS_MAX > 1) ? $clog2(VIS_MAX) : 1;
  localparam int RW      = (EFF_H > 1) ? $clog2(EFF_H) : 1;

  logic [CW-1:0] byte_column, byte_column_next;
  logic [RW-1:0] row_index, row_index_next;

  logic        bad_geom;
  logic [13:0] w_plus7;
  logic [10:0] vis;
  logic        last_col;
  logic        last_row;
  logic [7:0]  diff;
  logic [7:0]  tail_mask;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_wr     = accept;

  always_comb begin
    bad_geom = (cfg.frame_width == '0) || (cfg.frame_height == '0)
            || (32'(cfg.frame_width) > 32'(MAX_WIDTH))
            || (32'(cfg.frame_height) > 32'(MAX_HEIGHT));
    w_plus7  = 14'(cfg.frame_width) + 14'd7;
    vis      = w_plus7[13:3];
    last_col = (14'(byte_column) + 14'd1) >= 14'(vis);
    last_row = (14'(row_index) + 14'd1) >= 14'(cfg.frame_height);

    tail_mask = ~(8'hFF >> cfg.frame_width[2:0]);
    diff      = prev_byte ^ next_byte;
    if (last_col && (cfg.frame_width[2:0] != 3'd0)) diff = diff & tail_mask;

    q_entry.bad_geom  = bad_geom;
    q_entry.frame_end = last_col && last_row;
    q_entry.stride_ok = cfg.row_stride_bytes >= 16'(vis);
    q_entry.has_diff  = (diff != 8'd0);
    q_entry.ones      = mfdr_pkg::ones8(diff);
    q_entry.first_pos = mfdr_pkg::DIM_W'({byte_column, mfdr_pkg::first_set(diff)});
    q_entry.last_pos  = mfdr_pkg::DIM_W'({byte_column, mfdr_pkg::last_set(diff)});
    q_entry.row       = mfdr_pkg::DIM_W'(row_index);

    byte_column_next = byte_column;
    row_index_next   = row_index;
    if (accept) begin
      if (bad_geom || (last_col && last_row)) begin
        byte_column_next = '0;
        row_index_next   = '0;
      end else if (last_col) begin
        byte_column_next = '0;
        row_index_next   = row_index + 1'b1;
      end else begin
        byte_column_next = byte_column + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      byte_column <= '0;
      row_index   <= '0;
    end else begin
      byte_column <= byte_column_next;
      row_index   <= row_index_next;
    end
  end

endmodule

>>> rtl/mfdr_queue.sv
// mfdr_queue: small FIFO of classified entries between front and back.
// Depends on mfdr_pkg.
module mfdr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  mfdr_pkg::entry_t wr_entry,
  output logic             full,
  input  logic             rd,
  output logic             rd_valid,
  output mfdr_pkg::entry_t rd_entry
);

  localparam int DEPTH = mfdr_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  mfdr_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  assign full     = (count == (PW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wr_ptr] <= wr_entry;
  end

endmodule

>>> rtl/mfdr_back.sv
// mfdr_back: accumulates changed-pixel count and bounding box from queued
// entries; output loads at frame end or bad geometry. Depends on mfdr_pkg.
module mfdr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  mfdr_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  mfdr_pkg::entry_t  q_entry,
  output logic              q_rd,
  output logic              out_valid,
  input  logic              out_ready,
  output mfdr_pkg::result_t result
);

  localparam int DW = mfdr_pkg::DIM_W;

  logic [mfdr_pkg::COUNT_W-1:0] change_count, change_count_next;
  logic [DW-1:0] left_edge, left_edge_next;
  logic [DW-1:0] right_edge, right_edge_next;
  logic [DW-1:0] top_edge, top_edge_next;
  logic [DW-1:0] bottom_edge, bottom_edge_next;
  logic          any_change, any_change_next;

  logic              emits;
  logic              slot_free;
  logic [2*DW-1:0]   area;
  mfdr_pkg::result_t res_next;

  assign emits     = q_entry.bad_geom || q_entry.frame_end;
  assign slot_free = !out_valid || out_ready;
  assign q_rd      = q_valid && (!emits || slot_free);

  always_comb begin
    change_count_next = change_count + mfdr_pkg::COUNT_W'(q_entry.ones);
    left_edge_next    = left_edge;
    right_edge_next   = right_edge;
    top_edge_next     = top_edge;
    bottom_edge_next  = bottom_edge;
    any_change_next   = any_change;
    if (q_entry.has_diff) begin
      if (!any_change) begin
        left_edge_next  = q_entry.first_pos;
        right_edge_next = q_entry.last_pos;
        top_edge_next   = q_entry.row;
      end else begin
        if (q_entry.first_pos < left_edge) left_edge_next = q_entry.first_pos;
        if (q_entry.last_pos > right_edge) right_edge_next = q_entry.last_pos;
        if (q_entry.row < top_edge) top_edge_next = q_entry.row;
      end
      bottom_edge_next = q_entry.row;
      any_change_next  = 1'b1;
    end

    area     = cfg.frame_width * cfg.frame_height;
    res_next = '0;
    if (!q_entry.bad_geom && q_entry.stride_ok) begin
      res_next.result_valid    = 1'b1;
      res_next.changed_pixels  = change_count_next;
      res_next.compared_pixels = mfdr_pkg::COUNT_W'(area);
      if (any_change_next) begin
        res_next.has_bounds = 1'b1;
        res_next.box_x      = mfdr_pkg::COORD_W'(left_edge_next);
        res_next.box_y      = mfdr_pkg::COORD_W'(top_edge_next);
        res_next.box_width  = right_edge_next - left_edge_next + 1'b1;
        res_next.box_height = bottom_edge_next - top_edge_next + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      change_count <= '0;
      left_edge    <= '1;
      right_edge   <= '0;
      top_edge     <= '1;
      bottom_edge  <= '0;
      any_change   <= 1'b0;
    end else if (q_rd) begin
      if (emits) begin
        change_count <= '0;
        left_edge    <= '1;
        right_edge   <= '0;
        top_edge     <= '1;
        bottom_edge  <= '0;
        any_change   <= 1'b0;
      end else begin
        change_count <= change_count_next;
        left_edge    <= left_edge_next;
        right_edge   <= right_edge_next;
        top_edge     <= top_edge_next;
        bottom_edge  <= bottom_edge_next;
        any_change   <= any_change_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_rd && emits) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd && emits) result <= res_next;
  end

endmodule

>>> rtl/mono_frame_dirty_region_core.sv
// mono_frame_dirty_region_core: top level, APB register file and the
// front / queue / back pipeline. Depends on mfdr_pkg and rtl/mfdr_* modules.
//
// Usage:
//  - Input channel (in_valid/in_ready): one pair of old/new frame bytes per
//    request, MSB = leftmost pixel, visible bytes only, row after row.
//  - Output channel (out_valid/out_ready): one result request per frame,
//    loaded with the last byte of the last row; carries changed and compared
//    pixel counts and the bounding box (zeros when nothing changed).
//    result_valid = 0 (all fields 0) when the row stride is shorter than the
//    visible bytes. With unusable geometry every byte gives an all-zero result.
//  - Throughput: one byte pair per clock, sustained while no held result stalls
//    the back end's accumulate step, which retires one queued entry per cycle.
//  - Result path: the final accepted byte goes through the queue write, then the
//    back end's accumulate step loads the result; it waits longer while the
//    queue is backed up behind a held result.
//  - Stall: a held result waits in the output register; the 4-entry queue
//    keeps taking bytes until full, then in_ready drops until out_ready.
//  - Reset (rst, synchronous): registers go to 960 x 540, stride 120; queue,
//    position and accumulators clear. Any write to a listed register restarts
//    the frame; write registers only while the block is idle.
//  - Registers: 0x0 frame_width, 0x4 frame_height, 0x8 row_stride_bytes.
module mono_frame_dirty_region_core #(
  parameter int MAX_WIDTH  = mfdr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mfdr_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // APB configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mfdr_pkg::PADDR_W-1:0]   paddr,
  input  logic [mfdr_pkg::PDATA_W-1:0]   pwdata,
  output logic [mfdr_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     prev_byte,
  input  logic [7:0]                     next_byte,
  // output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           result_valid,
  output logic [mfdr_pkg::COUNT_W-1:0]   changed_pixels,
  output logic [mfdr_pkg::COUNT_W-1:0]   compared_pixels,
  output logic                           has_bounds,
  output logic [mfdr_pkg::COORD_W-1:0]   box_x,
  output logic [mfdr_pkg::COORD_W-1:0]   box_y,
  output logic [mfdr_pkg::DIM_W-1:0]     box_width,
  output logic [mfdr_pkg::DIM_W-1:0]     box_height
);

  mfdr_pkg::cfg_t    cfg;
  mfdr_pkg::entry_t  wr_entry;
  mfdr_pkg::entry_t  rd_entry;
  mfdr_pkg::result_t result;

  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       clr;
  logic       q_wr, q_rd, q_full, q_valid;

  // ---- register file ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  // any write to a listed register restarts frame accumulation
  assign clr     = cfg_wr && (reg_idx == mfdr_pkg::REG_FRAME_WIDTH
                           || reg_idx == mfdr_pkg::REG_FRAME_HEIGHT
                           || reg_idx == mfdr_pkg::REG_ROW_STRIDE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width      <= mfdr_pkg::FRAME_WIDTH_RST;
      cfg.frame_height     <= mfdr_pkg::FRAME_HEIGHT_RST;
      cfg.row_stride_bytes <= mfdr_pkg::ROW_STRIDE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        mfdr_pkg::REG_FRAME_WIDTH:  cfg.frame_width      <= pwdata[mfdr_pkg::DIM_W-1:0];
        mfdr_pkg::REG_FRAME_HEIGHT: cfg.frame_height     <= pwdata[mfdr_pkg::DIM_W-1:0];
        mfdr_pkg::REG_ROW_STRIDE:   cfg.row_stride_bytes <= pwdata[mfdr_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mfdr_pkg::REG_FRAME_WIDTH:  prdata = mfdr_pkg::PDATA_W'(cfg.frame_width);
      mfdr_pkg::REG_FRAME_HEIGHT: prdata = mfdr_pkg::PDATA_W'(cfg.frame_height);
      mfdr_pkg::REG_ROW_STRIDE:   prdata = mfdr_pkg::PDATA_W'(cfg.row_stride_bytes);
      default:                    prdata = '0;
    endcase
  end

  // ---- front: position tracking and classification ----
  mfdr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .clr       (clr),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .prev_byte (prev_byte),
    .next_byte (next_byte),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_entry   (wr_entry)
  );

  // ---- decoupling queue ----
  mfdr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_entry (wr_entry),
    .full     (q_full),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rd_entry (rd_entry)
  );

  // ---- back: accumulation and result register ----
  mfdr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .clr       (clr),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (rd_entry),
    .q_rd      (q_rd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign result_valid    = result.result_valid;
  assign changed_pixels  = result.changed_pixels;
  assign compared_pixels = result.compared_pixels;
  assign has_bounds      = result.has_bounds;
  assign box_x           = result.box_x;
  assign box_y           = result.box_y;
  assign box_width       = result.box_width;
  assign box_height      = result.box_height;

endmodule

>>> test/tb_top.sv
// tb_top: self-checking bench for mono_frame_dirty_region_core. It streams byte pairs
// of old/new 1bpp frames over the valid/ready input and programs the geometry over APB.
// Each result is checked against a frame-difference model. Depends on mfdr_pkg and the rtl.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Index 3 is decoded by paddr but backs no register; writes to it must be dropped.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Post-result drain: the queue write and result register plus the 4-deep entry queue, with margin.
  localparam int DRAIN_CYCLES = 8;
  // Longest correct quiet stretch is the longest idle_len gap or stall plus the drain.
  localparam int STALL_LIMIT  = 1000;

  // Density of changes inside a streamed frame
  typedef enum int {DENS_NONE, DENS_SPARSE, DENS_DENSE} density_t;

  // --------------------------------------------------------------------------
  // Frame-difference predictor plus the queue of results still owed by the DUT
  // --------------------------------------------------------------------------
  class dirty_region_board;
    mfdr_pkg::result_t expected_regions[$];
    int          mismatches;
    int          checked;
    // programmed geometry
    int unsigned width_px;
    int unsigned height_rows;
    int unsigned stride_bytes;
    // running frame state
    int unsigned byte_col;
    int unsigned row_idx;
    int unsigned change_total;
    int unsigned left_col;
    int unsigned right_col;
    int unsigned top_row;
    int unsigned bottom_row;
    bit          seen_change;

    function new();
      width_px     = mfdr_pkg::FRAME_WIDTH_RST;
      height_rows  = mfdr_pkg::FRAME_HEIGHT_RST;
      stride_bytes = mfdr_pkg::ROW_STRIDE_RST;
      mismatches   = 0;
      checked      = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      byte_col     = 0;
      row_idx      = 0;
      change_total = 0;
      left_col     = 'hFFF;
      right_col    = 0;
      top_row      = 'hFFF;
      bottom_row   = 0;
      seen_change  = 1'b0;
    endfunction

    // A write to a listed register restarts the frame; other indexes are dropped.
    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        mfdr_pkg::REG_FRAME_WIDTH:  width_px     = data[mfdr_pkg::DIM_W-1:0];
        mfdr_pkg::REG_FRAME_HEIGHT: height_rows  = data[mfdr_pkg::DIM_W-1:0];
        mfdr_pkg::REG_ROW_STRIDE:   stride_bytes = data[mfdr_pkg::STRIDE_W-1:0];
        default: return;
      endcase
      restart_frame();
    endfunction

    // Called for every accepted byte pair.
    function void take_pair(logic [7:0] old_px, logic [7:0] new_px);
      mfdr_pkg::result_t r;
      int unsigned vis;
      logic [7:0]  diff;
      logic [7:0]  keep;
      bit          row_end;
      int unsigned lo;
      int unsigned hi;
      r = '0;
      // Unusable geometry: every pair flushes and yields an all-zero result.
      if (width_px == 0 || height_rows == 0 ||
          width_px > mfdr_pkg::MAX_WIDTH_DEF || height_rows > mfdr_pkg::MAX_HEIGHT_DEF) begin
        restart_frame();
        expected_regions.push_back(r);
        return;
      end
      vis     = (width_px + 7) >> 3;
      row_end = (byte_col + 1 >= vis);
      diff    = old_px ^ new_px;
      // Pixels past the frame width in the last byte of a row never count.
      if (row_end && width_px[2:0] != 3'd0) begin
        keep = 8'hFF << (8 - int'(width_px[2:0]));
        diff = diff & keep;
      end
      if (diff != 8'h00) begin
        change_total += $countones(diff);
        lo = 0;
        while (lo < 7 && !diff[7-lo]) lo++;
        hi = 7;
        while (hi > 0 && !diff[7-hi]) hi--;
        lo += byte_col * 8;
        hi += byte_col * 8;
        if (!seen_change) begin
          left_col  = lo;
          right_col = hi;
          top_row   = row_idx;
        end else begin
          if (lo < left_col) left_col = lo;
          if (hi > right_col) right_col = hi;
          if (row_idx < top_row) top_row = row_idx;
        end
        bottom_row  = row_idx;
        seen_change = 1'b1;
      end
      if (!row_end) begin
        byte_col++;
        return;
      end
      byte_col = 0;
      if (row_idx + 1 < height_rows) begin
        row_idx++;
        return;
      end
      // Frame done. A short stride zeroes the whole result.
      if (stride_bytes >= vis) begin
        r.result_valid    = 1'b1;
        r.changed_pixels  = change_total[mfdr_pkg::COUNT_W-1:0];
        r.compared_pixels = mfdr_pkg::COUNT_W'(width_px * height_rows);
        if (seen_change) begin
          r.has_bounds = 1'b1;
          r.box_x      = left_col[mfdr_pkg::COORD_W-1:0];
          r.box_y      = top_row[mfdr_pkg::COORD_W-1:0];
          r.box_width  = mfdr_pkg::DIM_W'(right_col - left_col + 1);
          r.box_height = mfdr_pkg::DIM_W'(bottom_row - top_row + 1);
        end
      end
      restart_frame();
      expected_regions.push_back(r);
    endfunction

    function int field_diff(string name, logic [31:0] want, logic [31:0] got);
      if (got === want) return 0;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      return 1;
    endfunction

    // Called for every accepted result.
    function void check_result(mfdr_pkg::result_t got);
      mfdr_pkg::result_t want;
      checked++;
      if (expected_regions.size() == 0) begin
        $display("%0t ns: result with nothing expected, expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_regions.pop_front();
      mismatches += field_diff("result_valid",    want.result_valid,    got.result_valid);
      mismatches += field_diff("changed_pixels",  want.changed_pixels,  got.changed_pixels);
      mismatches += field_diff("compared_pixels", want.compared_pixels, got.compared_pixels);
      mismatches += field_diff("has_bounds",      want.has_bounds,      got.has_bounds);
      mismatches += field_diff("box_x",           want.box_x,           got.box_x);
      mismatches += field_diff("box_y",           want.box_y,           got.box_y);
      mismatches += field_diff("box_width",       want.box_width,       got.box_width);
      mismatches += field_diff("box_height",      want.box_height,      got.box_height);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [mfdr_pkg::PADDR_W-1:0]  paddr     = '0;
  logic [mfdr_pkg::PDATA_W-1:0]  pwdata    = '0;
  logic [mfdr_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic [7:0]                    prev_byte = '0;
  logic [7:0]                    next_byte = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          result_valid;
  logic [mfdr_pkg::COUNT_W-1:0]  changed_pixels;
  logic [mfdr_pkg::COUNT_W-1:0]  compared_pixels;
  logic                          has_bounds;
  logic [mfdr_pkg::COORD_W-1:0]  box_x;
  logic [mfdr_pkg::COORD_W-1:0]  box_y;
  logic [mfdr_pkg::DIM_W-1:0]    box_width;
  logic [mfdr_pkg::DIM_W-1:0]    box_height;

  mono_frame_dirty_region_core u_top (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .prev_byte       (prev_byte),
    .next_byte       (next_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_valid    (result_valid),
    .changed_pixels  (changed_pixels),
    .compared_pixels (compared_pixels),
    .has_bounds      (has_bounds),
    .box_x           (box_x),
    .box_y           (box_y),
    .box_width       (box_width),
    .box_height      (box_height)
  );

  dirty_region_board board = new();

  // When set, neither side idles: back-to-back requests and an always-ready sink.
  bit steady = 1'b0;

  always #1 clk = ~clk;

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Result sink: random backpressure, check at each accepted request.
  // All sampling happens at the edge, before any NBA of that edge lands.
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      stall_left = idle_len();
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    mfdr_pkg::result_t seen;
    if (!rst && out_valid && out_ready) begin
      seen.result_valid    = result_valid;
      seen.changed_pixels  = changed_pixels;
      seen.compared_pixels = compared_pixels;
      seen.has_bounds      = has_bounds;
      seen.box_x           = box_x;
      seen.box_y           = box_y;
      seen.box_width       = box_width;
      seen.box_height      = box_height;
      board.check_result(seen);
    end
  end

  // Watchdog: ends the run if no request, result or register write moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pwrite && pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers. All tasks are entered and left right after a rising edge.
  // --------------------------------------------------------------------------

  // One byte-pair request; valid and payload hold until the DUT takes it.
  task automatic send_pair(input logic [7:0] old_px, input logic [7:0] new_px);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    prev_byte <= old_px;
    next_byte <= new_px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_pair(old_px, new_px);
  endtask

  // Stop sending, let every owed result come back, then let the pipe drain:
  // trailing pairs of an unfinished frame produce nothing to wait on.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.expected_regions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register lands at the access edge.
  // psel stays up so back-to-back writes never lower and raise it in one step.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.write_reg(idx, data);
  endtask

  // Program all three registers while idle. With junk set, unused high bits of
  // pwdata are randomized; the DUT must ignore them.
  task automatic configure(input int unsigned w, input int unsigned h,
                           input int unsigned stride, input bit junk);
    logic [31:0] hi_dim;
    logic [31:0] hi_stride;
    hi_dim    = junk ? ($urandom() << mfdr_pkg::DIM_W) : 32'd0;
    hi_stride = junk ? ($urandom() << mfdr_pkg::STRIDE_W) : 32'd0;
    settle();
    write_reg(mfdr_pkg::REG_FRAME_WIDTH,  hi_dim | w);
    write_reg(mfdr_pkg::REG_FRAME_HEIGHT, hi_dim | h);
    write_reg(mfdr_pkg::REG_ROW_STRIDE,   hi_stride | stride);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_random_pairs(input int count, input density_t dens);
    logic [7:0] old_px;
    logic [7:0] new_px;
    for (int i = 0; i < count; i++) begin
      old_px = $urandom();
      case (dens)
        DENS_NONE:   new_px = old_px;
        DENS_SPARSE: new_px = ($urandom_range(0, 9) == 0) ?
                              old_px ^ (8'h01 << $urandom_range(0, 7)) : old_px;
        default:     new_px = $urandom();
      endcase
      send_pair(old_px, new_px);
    end
  endtask

  // Unchanged frame except for up to two chosen pairs (position -1 = unused).
  task automatic send_marked_frame(input int count,
                                   input int at_a, input logic [7:0] old_a,
                                   input logic [7:0] new_a,
                                   input int at_b, input logic [7:0] old_b,
                                   input logic [7:0] new_b);
    logic [7:0] same;
    for (int i = 0; i < count; i++) begin
      same = $urandom();
      if (i == at_a)      send_pair(old_a, new_a);
      else if (i == at_b) send_pair(old_b, new_b);
      else                send_pair(same, same);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned w;
    int unsigned h;
    int unsigned stride;
    int unsigned vis;
    int          pick;
    int          count;
    int          random_pairs;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry (960x540): a few pairs of a frame that the next write abandons.
    send_pair(8'h00, 8'hFF);
    send_pair(8'hFF, 8'h00);
    send_pair(8'hA5, 8'h5A);

    // Single-pixel frame: only the MSB counts, the rest is masked off.
    configure(1, 1, 1, 1'b0);
    send_pair(8'h00, 8'hFF);   // one change at column 0
    send_pair(8'hFF, 8'hFF);   // no change in frame: zero box
    send_pair(8'h7F, 8'h00);   // change only in masked bits
    send_pair(8'hFF, 8'h7F);

    // Write to an unlisted index mid-frame must not restart accumulation.
    configure(16, 2, 2, 1'b0);
    send_pair(8'h00, 8'h00);
    send_pair(8'h00, 8'h01);   // column 15, row 0
    settle();
    write_reg(REG_UNUSED, $urandom());
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    send_pair(8'h80, 8'h00);   // column 0, row 1
    send_pair(8'h00, 8'h00);

    // Stride shorter than the visible bytes: walked, but reported invalid.
    configure(17, 3, 2, 1'b0);
    send_random_pairs(9, DENS_DENSE);
    configure(9, 1, 0, 1'b0);
    send_random_pairs(2, DENS_DENSE);

    // Unusable geometry: every pair yields an all-zero result immediately.
    configure(0, 5, 10, 1'b0);
    send_random_pairs(2, DENS_DENSE);
    configure(4097, 1, 1, 1'b0);
    send_random_pairs(1, DENS_DENSE);
    configure(8191, 8191, 65535, 1'b0);
    send_random_pairs(1, DENS_DENSE);
    configure(5, 0, 1, 1'b0);
    send_random_pairs(1, DENS_DENSE);
    configure(5, 4097, 1, 1'b0);
    send_random_pairs(1, DENS_DENSE);

    // Widest frame: full-width box from column 0 to the last column.
    configure(4096, 1, 512, 1'b0);
    send_marked_frame(512, 0, 8'hFF, 8'h7F, 511, 8'h00, 8'h01);

    // Tall frame, widest stride: box from the first row to the last.
    configure(8, 256, 65535, 1'b0);
    send_marked_frame(256, 0, 8'h00, 8'hFF, 255, 8'hFF, 8'h00);

    // Random phases: mostly small well-formed frames with random content, some
    // wide ones, short strides, unusable geometry and abandoned partial frames.
    random_pairs = 0;
    while (random_pairs < 400) begin
      steady = ($urandom_range(0, 4) == 0);
      pick   = $urandom_range(0, 99);
      if (pick < 6) begin
        case ($urandom_range(0, 3))
          0: begin w = 0;                        h = $urandom_range(0, 8191); end
          1: begin w = $urandom_range(4097, 8191); h = $urandom_range(0, 8191); end
          2: begin w = $urandom_range(1, 4096);  h = 0; end
          default: begin
            w = $urandom_range(1, 4096);
            h = $urandom_range(4097, 8191);
          end
        endcase
        configure(w, h, $urandom_range(0, 65535), $urandom_range(0, 3) == 0);
        count = $urandom_range(1, 6);
        send_random_pairs(count, DENS_DENSE);
        random_pairs += count;
      end else begin
        if (pick < 11) begin
          w = $urandom_range(301, 1024);
          h = 1;
        end else if (pick < 30) begin
          w = $urandom_range(41, 300);
          h = $urandom_range(1, 4);
        end else begin
          w = $urandom_range(1, 40);
          h = $urandom_range(1, 12);
        end
        vis = (w + 7) / 8;
        if ($urandom_range(0, 4) == 0)       stride = $urandom_range(0, vis - 1);
        else if ($urandom_range(0, 9) == 0)  stride = $urandom_range(vis, 65535);
        else                                 stride = vis + $urandom_range(0, 3);
        configure(w, h, stride, $urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 3)) begin
          send_random_pairs(vis * h, density_t'($urandom_range(0, 2)));
          random_pairs += vis * h;
        end
        // Abandoned frame: the next register write must discard it.
        if ($urandom_range(0, 4) == 0 && vis * h > 1) begin
          count = $urandom_range(1, vis * h - 1);
          send_random_pairs(count, DENS_DENSE);
          random_pairs += count;
        end
      end
    end

    steady = 1'b0;
    settle();

    if (board.mismatches == 0 && board.expected_regions.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
